[rtl/pulse_frequency_presence_detector_defines.svh]
// Assertion macros for the pulse frequency presence detector.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PULSE_FREQUENCY_PRESENCE_DETECTOR_DEFINES_SVH
`define PULSE_FREQUENCY_PRESENCE_DETECTOR_DEFINES_SVH

`ifndef SYNTH
`define PFPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PFPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PFPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/pfpd_pkg.sv]
// Package of the pulse frequency presence detector: constants, codes and the
// command and status structs shared by controller and datapath. No dependencies.
package pfpd_pkg;

	localparam int unsigned MEASUREMENTS_DEF = 10;
	localparam int unsigned COUNT_BITS_DEF   = 16;

	localparam int unsigned SUM_W  = 28;
	localparam int unsigned FREQ_W = 24;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [FREQ_W-1:0] FREQ_MAX = 24'hFFFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TPS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd4;

	localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
	localparam logic [15:0] TPS_RST      = 16'd1000;
	localparam logic [15:0] CENTER_A_RST = 16'd100;
	localparam logic [15:0] CENTER_B_RST = 16'd200;
	localparam logic [7:0]  TOL_RST      = 8'd5;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_WAIT0 = 2'd1;
	localparam logic [1:0] PH_WAIT1 = 2'd2;
	localparam logic [1:0] PH_WAIT2 = 2'd3;

	typedef struct packed {
		logic capture;
		logic eval;
		logic div_start;
		logic div_mean;
		logic fin;
		logic mean;
		logic load_out;
	} pfpd_cmd_t;

	typedef struct packed {
		logic fin_need;
		logic fin_div;
		logic run_end;
		logic div_done;
	} pfpd_status_t;

endpackage

[rtl/pfpd_if.sv]
// Channel interfaces of the pulse frequency presence detector: sample input and
// result output, each with valid, ready and payload. No dependencies.
interface pfpd_sample_if;
	logic valid;
	logic ready;
	logic level;
	logic start_req;
	logic clear_seen;

	modport source (output valid, output level, output start_req, output clear_seen,
		input ready);
	modport sink (input valid, input level, input start_req, input clear_seen,
		output ready);
endinterface

interface pfpd_result_if;
	logic        valid;
	logic        ready;
	logic        busy_res;
	logic        done_res;
	logic        signal_present;
	logic [23:0] avg_frequency;
	logic [15:0] last_period_ticks;

	modport source (output valid, output busy_res, output done_res, output signal_present,
		output avg_frequency, output last_period_ticks, input ready);
	modport sink (input valid, input busy_res, input done_res, input signal_present,
		input avg_frequency, input last_period_ticks, output ready);
endinterface

[rtl/pfpd_div.sv]
// Restoring serial divider, one quotient bit per cycle for SUM_W quotient bits.
// Depends on pfpd_pkg.
module pfpd_div #(
	parameter int unsigned DIV_W = pfpd_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pfpd_pkg::SUM_W-1:0] num,
	input  logic [DIV_W-1:0]           den,
	output logic                       done,
	output logic [pfpd_pkg::SUM_W-1:0] quot
);
	import pfpd_pkg::*;

	localparam int unsigned CNT_W = $clog2(SUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] num_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

[rtl/pfpd_dp.sv]
// Datapath of the pulse frequency presence detector: configuration registers,
// measurement counters, accumulator, mean by reciprocal multiplication, presence
// window and result register. Depends on pfpd_pkg and pfpd_div.
module pfpd_dp #(
	parameter int unsigned MEASUREMENTS = pfpd_pkg::MEASUREMENTS_DEF,
	parameter int unsigned COUNT_BITS   = pfpd_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pfpd_pkg::pfpd_cmd_t             cmd,
	output pfpd_pkg::pfpd_status_t          status,
	input  logic                            cfg_we,
	input  logic [pfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            level,
	input  logic                            start_req,
	input  logic                            clear_seen,
	output logic                            busy_res,
	output logic                            done_res,
	output logic                            signal_present,
	output logic [pfpd_pkg::FREQ_W-1:0]     avg_frequency,
	output logic [15:0]                     last_period_ticks
);
	import pfpd_pkg::*;

	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam int unsigned MEAN_SHIFT = SUM_W + $clog2(MEASUREMENTS);
	localparam int unsigned RECIP_W    = SUM_W + 2;
	localparam int unsigned PROD_W     = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(((64'd1 << MEAN_SHIFT) +
		64'(MEASUREMENTS) - 64'd1) / 64'(MEASUREMENTS));

	logic [15:0] timeout_q;
	logic [15:0] tps_q;
	logic [15:0] center_a_q;
	logic [15:0] center_b_q;
	logic [7:0]  tol_q;

	logic                  lvl_q;
	logic                  start_q;
	logic                  clr_q;
	logic [1:0]            phase_q;
	logic                  wait_level_q;
	logic [COUNT_BITS-1:0] wait_count_q;
	logic [COUNT_BITS-1:0] period_count_q;
	logic [3:0]            index_q;
	logic [SUM_W-1:0]      sum_q;
	logic                  seen_q;
	logic [FREQ_W-1:0]     mean_hold_q;
	logic [15:0]           period_hold_q;
	logic                  done_q;
	logic                  fin_q;
	logic                  third_q;
	logic                  zero_q;
	logic [COUNT_BITS-1:0] fin_period_q;
	logic [SUM_W-1:0]      mean_quot_q;

	logic [COUNT_BITS-1:0] pc_inc;
	logic [COUNT_BITS-1:0] wc_inc;
	logic                  timeout;
	logic [FREQ_W-1:0]     freq_f;
	logic [SUM_W-1:0]      sum_next;
	logic [3:0]            index_next;
	logic                  run_end;
	logic [15:0]           period_sat;
	logic [SUM_W-1:0]      quot;
	logic                  div_done;
	logic [SUM_W-1:0]      div_num;
	logic [COUNT_BITS-1:0] div_den;
	logic [PROD_W-1:0]     mean_prod;
	logic [FREQ_W-1:0]     mean_sat;
	logic [FREQ_W:0]       c_a;
	logic [FREQ_W:0]       c_b;
	logic [FREQ_W:0]       tol_w;
	logic [FREQ_W:0]       mean_w;
	logic                  win_hit;

	assign pc_inc = (phase_q != PH_WAIT0 && period_count_q < CMAX) ?
		period_count_q + COUNT_BITS'(1) : period_count_q;
	assign wc_inc = (wait_count_q < CMAX) ? wait_count_q + COUNT_BITS'(1) : wait_count_q;
	assign timeout = (32'(wc_inc) > 32'(timeout_q)) || (wc_inc == CMAX);

	assign freq_f = third_q ? (zero_q ? FREQ_MAX : quot[FREQ_W-1:0]) : '0;
	assign sum_next = sum_q + SUM_W'(freq_f);
	assign index_next = index_q + 4'd1;
	assign run_end = index_next >= 4'(MEASUREMENTS);
	assign period_sat = (32'(fin_period_q) > 32'(16'hFFFF)) ? 16'hFFFF : 16'(fin_period_q);

	assign div_num = SUM_W'({tps_q, 8'h00});
	assign div_den = fin_period_q;

	pfpd_div #(
		.DIV_W(COUNT_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (quot)
	);

	assign mean_prod = PROD_W'(sum_q) * PROD_W'(MEAN_RECIP);

	always_ff @(posedge clk) begin
		if (cmd.div_mean) begin
			mean_quot_q <= SUM_W'(mean_prod >> MEAN_SHIFT);
		end
	end

	assign mean_sat = (mean_quot_q > SUM_W'(FREQ_MAX)) ? FREQ_MAX : mean_quot_q[FREQ_W-1:0];
	assign mean_w   = {1'b0, mean_sat};
	assign c_a      = {1'b0, center_a_q, 8'h00};
	assign c_b      = {1'b0, center_b_q, 8'h00};
	assign tol_w    = {9'd0, tol_q, 8'h00};
	assign win_hit  = (mean_w < c_a + tol_w && mean_w + tol_w > c_a) ||
		(mean_w < c_b + tol_w && mean_w + tol_w > c_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			tps_q      <= TPS_RST;
			center_a_q <= CENTER_A_RST;
			center_b_q <= CENTER_B_RST;
			tol_q      <= TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT:  timeout_q  <= cfg_wdata;
				REG_TPS:      tps_q      <= cfg_wdata;
				REG_CENTER_A: center_a_q <= cfg_wdata;
				REG_CENTER_B: center_b_q <= cfg_wdata;
				REG_TOL:      tol_q      <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lvl_q   <= level;
			start_q <= start_req;
			clr_q   <= clear_seen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			wait_level_q   <= 1'b0;
			wait_count_q   <= '0;
			period_count_q <= '0;
			index_q        <= '0;
			sum_q          <= '0;
			seen_q         <= 1'b0;
			mean_hold_q    <= '0;
			period_hold_q  <= '0;
			done_q         <= 1'b0;
			fin_q          <= 1'b0;
			third_q        <= 1'b0;
			zero_q         <= 1'b0;
			fin_period_q   <= '0;
		end else if (cmd.eval) begin
			done_q  <= 1'b0;
			fin_q   <= 1'b0;
			third_q <= 1'b0;
			zero_q  <= 1'b0;
			if (clr_q) begin
				seen_q <= 1'b0;
			end
			if (phase_q == PH_IDLE) begin
				if (start_q) begin
					phase_q        <= PH_WAIT0;
					wait_level_q   <= lvl_q;
					wait_count_q   <= '0;
					period_count_q <= '0;
					index_q        <= '0;
					sum_q          <= '0;
				end
			end else if (lvl_q != wait_level_q) begin
				wait_level_q <= lvl_q;
				wait_count_q <= '0;
				case (phase_q)
					PH_WAIT0: begin
						period_count_q <= '0;
						phase_q        <= PH_WAIT1;
					end
					PH_WAIT1: begin
						period_count_q <= pc_inc;
						phase_q        <= PH_WAIT2;
					end
					default: begin
						period_count_q <= pc_inc;
						fin_q          <= 1'b1;
						third_q        <= 1'b1;
						zero_q         <= pc_inc == '0;
						fin_period_q   <= pc_inc;
					end
				endcase
			end else begin
				period_count_q <= pc_inc;
				wait_count_q   <= wc_inc;
				if (timeout) begin
					fin_q   <= 1'b1;
					third_q <= 1'b0;
				end
			end
		end else if (cmd.fin) begin
			sum_q          <= sum_next;
			period_hold_q  <= third_q ? period_sat : 16'd0;
			wait_level_q   <= lvl_q;
			wait_count_q   <= '0;
			period_count_q <= '0;
			if (run_end) begin
				index_q <= '0;
				phase_q <= PH_IDLE;
			end else begin
				index_q <= index_next;
				phase_q <= PH_WAIT0;
			end
		end else if (cmd.mean) begin
			mean_hold_q <= mean_sat;
			seen_q      <= win_hit;
			done_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			busy_res          <= phase_q != PH_IDLE;
			done_res          <= done_q;
			signal_present    <= seen_q;
			avg_frequency     <= mean_hold_q;
			last_period_ticks <= period_hold_q;
		end
	end

	assign status.fin_need = fin_q;
	assign status.fin_div  = third_q && !zero_q;
	assign status.run_end  = run_end;
	assign status.div_done = div_done;

endmodule

[rtl/pfpd_ctrl.sv]
// Controller of the pulse frequency presence detector: sequences one sample
// through evaluation, division, closing, mean and result hand-off.
// Depends on pfpd_pkg and pulse_frequency_presence_detector_defines.svh.
`include "pulse_frequency_presence_detector_defines.svh"

module pfpd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  pfpd_pkg::pfpd_status_t status,
	output pfpd_pkg::pfpd_cmd_t    cmd
);
	import pfpd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_ROUTE = 3'd2;
	localparam logic [2:0] S_FDIV  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_MDIV  = 3'd5;
	localparam logic [2:0] S_MEAN  = 3'd6;
	localparam logic [2:0] S_PUSH  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_ROUTE;
			end
			S_ROUTE: begin
				if (!status.fin_need) begin
					state_d = S_PUSH;
				end else if (status.fin_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_FDIV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FDIV: begin
				if (status.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				if (status.run_end) begin
					state_d = S_MDIV;
				end else begin
					state_d = S_PUSH;
				end
			end
			S_MDIV: begin
				cmd.div_mean = 1'b1;
				state_d      = S_MEAN;
			end
			S_MEAN: begin
				cmd.mean = 1'b1;
				state_d  = S_PUSH;
			end
			S_PUSH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`PFPD_ASSERT_NXT(a_accept_evals, clk, arst_n, in_valid && in_ready, state_q == S_EVAL, "accepted transaction not evaluated")
	`PFPD_ASSERT_NXT(a_div_start_waits, clk, arst_n, cmd.div_start, state_q == S_FDIV, "divider started outside the division state")
	`PFPD_ASSERT_IMP(a_div_done_state, clk, arst_n, status.div_done, state_q == S_FDIV, "divider result arrived unexpectedly")
	`PFPD_ASSERT_NXT(a_load_sets_valid, clk, arst_n, cmd.load_out, out_valid_q, "loaded result not offered")

endmodule

[rtl/pulse_frequency_presence_detector.sv]
// Top level of the pulse frequency presence detector: sample and result channels,
// configuration write port, controller and datapath.
// Depends on pfpd_pkg, pfpd_if, pfpd_ctrl and pfpd_dp.
//
// Usage: one sample transaction per tick carries level, start_req and clear_seen.
// Every sample gives exactly one result transaction with busy_res, done_res,
// signal_present, avg_frequency (Q16.8 Hz) and last_period_ticks.
// Configuration is written on cfg_we with cfg_index 0..4 (timeout, ticks per
// second, first center, second center, tolerance); the user must do so only
// while the block is idle, and no logic in the block enforces this.
// Flow: an ordinary sample is captured on acceptance, passes the evaluation and
// routing states and is loaded into the output register; the controller then
// returns to idle for the next sample. A closing timeout adds the closing
// state, a third level change adds the 28-step serial frequency division and the
// closing state, and a run's last sample also adds the mean and window check.
// One sample is processed at a time; a new sample is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, the next result waits in the controller until the
// output register frees, and no further sample is accepted meanwhile.
// Reset loads the configuration defaults, clears all counters and the presence
// flag, and leaves the block idle with no result pending.
module pulse_frequency_presence_detector #(
	parameter int unsigned MEASUREMENTS = pfpd_pkg::MEASUREMENTS_DEF,
	parameter int unsigned COUNT_BITS   = pfpd_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pfpd_sample_if.sink                     sample,
	pfpd_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [pfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pfpd_pkg::*;

	pfpd_cmd_t    cmd;
	pfpd_status_t status;

	pfpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pfpd_dp #(
		.MEASUREMENTS(MEASUREMENTS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.level            (sample.level),
		.start_req        (sample.start_req),
		.clear_seen       (sample.clear_seen),
		.busy_res         (result.busy_res),
		.done_res         (result.done_res),
		.signal_present   (result.signal_present),
		.avg_frequency    (result.avg_frequency),
		.last_period_ticks(result.last_period_ticks)
	);

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the pulse frequency presence detector: sample transactions with
// random gaps and result stalls, every result predicted in the bench and compared in order.
// Depends on pfpd_pkg, the channel interfaces in pfpd_if and the detector RTL.
module tb_top;
	import pfpd_pkg::*;

	localparam int unsigned MEAS = MEASUREMENTS_DEF;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam int unsigned DIR_ROWS = 20;
	localparam int unsigned RANDOM_ITEMS = 480;
	localparam int unsigned FIXED_SETTINGS = 4;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned DRAIN_CYCLES = 70;
	localparam int unsigned HOLD_AFTER = 150;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned LIMIT_CYCLES = 1000000;
	localparam int unsigned REPORT_MAX = 10;

	typedef enum int unsigned {
		SHAPE_SQUARE,
		SHAPE_JITTER,
		SHAPE_NOISE,
		SHAPE_STUCK
	} wave_shape_e;

	typedef struct packed {
		logic level;
		logic start_req;
		logic clear_seen;
	} pin_sample_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic              present;
		logic [FREQ_W-1:0] mean;
		logic [15:0]       period;
	} det_status_t;

	typedef struct packed {
		pin_sample_t pin;
		logic        known;
		det_status_t want;
	} dir_row_t;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{'{1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 24'd0, 16'd0}},
		'{'{1'b1, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 24'd0, 16'd0}},
		'{'{1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 24'd0, 16'd0}},
		'{'{1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 24'd0, 16'd0}},
		'{'{1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 24'd0, 16'd2}},
		'{'{1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{1'b1, 1'b0, 1'b0}, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pfpd_sample_if smp ();
	pfpd_result_if res ();

	pulse_frequency_presence_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	logic [15:0]       reg_timeout;
	logic [15:0]       reg_tps;
	logic [15:0]       reg_center_a;
	logic [15:0]       reg_center_b;
	logic [7:0]        reg_tol;
	logic [1:0]        det_phase;
	logic              det_wait_level;
	logic [15:0]       det_wait_cnt;
	logic [15:0]       det_per_cnt;
	logic [3:0]        det_index;
	logic [SUM_W-1:0]  det_sum;
	logic              det_seen;
	logic [FREQ_W-1:0] det_mean;
	logic [15:0]       det_period;

	det_status_t predicted_status [$];
	int unsigned samples_sent = 0;
	int unsigned mismatches = 0;
	int unsigned runs_done = 0;
	int unsigned presence_hits = 0;
	int unsigned settings_used = 0;
	int unsigned burst_left = 0;
	int unsigned phase_hi = 2;
	int unsigned phase_lo = 3;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic in_window(input logic [FREQ_W-1:0] avg, input logic [15:0] center);
		longint c;
		longint t;
		longint m;
		c = longint'(center) * 256;
		t = longint'(reg_tol) * 256;
		m = longint'(avg);
		return (m < c + t) && (m > c - t);
	endfunction

	task automatic close_measurement(input logic [FREQ_W-1:0] freq, input logic [15:0] per,
		input logic lvl, output logic fin);
		logic [SUM_W-1:0] avg_full;
		det_sum = det_sum + SUM_W'(freq);
		det_period = per;
		det_index = det_index + 4'd1;
		det_wait_level = lvl;
		det_wait_cnt = '0;
		det_per_cnt = '0;
		det_phase = PH_WAIT0;
		fin = 1'b0;
		if (det_index >= MEAS) begin
			avg_full = SUM_W'(det_sum / MEAS);
			det_mean = (avg_full > FREQ_MAX) ? FREQ_MAX : avg_full[FREQ_W-1:0];
			det_seen = in_window(det_mean, reg_center_a) || in_window(det_mean, reg_center_b);
			det_phase = PH_IDLE;
			det_index = '0;
			fin = 1'b1;
			runs_done++;
			if (det_seen) begin
				presence_hits++;
			end
		end
	endtask

	task automatic advance_detector(input pin_sample_t s, output det_status_t st);
		logic              done;
		logic [31:0]       quot;
		logic [FREQ_W-1:0] freq;
		done = 1'b0;
		if (s.clear_seen) begin
			det_seen = 1'b0;
		end
		if (det_phase == PH_IDLE) begin
			if (s.start_req) begin
				det_phase = PH_WAIT0;
				det_wait_level = s.level;
				det_wait_cnt = '0;
				det_per_cnt = '0;
				det_index = '0;
				det_sum = '0;
			end
		end else begin
			if (det_phase != PH_WAIT0 && det_per_cnt != CNT_MAX) begin
				det_per_cnt = det_per_cnt + 16'd1;
			end
			if (s.level != det_wait_level) begin
				det_wait_level = s.level;
				det_wait_cnt = '0;
				case (det_phase)
					PH_WAIT0: begin
						det_per_cnt = '0;
						det_phase = PH_WAIT1;
					end
					PH_WAIT1: begin
						det_phase = PH_WAIT2;
					end
					default: begin
						if (det_per_cnt == '0) begin
							freq = FREQ_MAX;
						end else begin
							quot = {8'd0, reg_tps, 8'd0} / {16'd0, det_per_cnt};
							freq = (quot > FREQ_MAX) ? FREQ_MAX : quot[FREQ_W-1:0];
						end
						close_measurement(freq, det_per_cnt, s.level, done);
					end
				endcase
			end else begin
				if (det_wait_cnt != CNT_MAX) begin
					det_wait_cnt = det_wait_cnt + 16'd1;
				end
				if (det_wait_cnt > reg_timeout || det_wait_cnt == CNT_MAX) begin
					close_measurement('0, '0, s.level, done);
				end
			end
		end
		st = '{det_phase != PH_IDLE, done, det_seen, det_mean, det_period};
	endtask

	task automatic offer_sample(input pin_sample_t s, input logic known, input det_status_t want);
		det_status_t st;
		int unsigned gap;
		int unsigned pick;
		advance_detector(s, st);
		predicted_status.push_back(known ? want : st);
		if (burst_left != 0) begin
			burst_left--;
			gap = 0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				burst_left = $urandom_range(20, 80);
			end
			if (pick < 45) begin
				gap = 0;
			end else if (pick < 85) begin
				gap = $urandom_range(1, 3);
			end else if (pick < 96) begin
				gap = $urandom_range(4, 12);
			end else begin
				gap = $urandom_range(20, 80);
			end
		end
		if (gap != 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.level <= s.level;
		smp.start_req <= s.start_req;
		smp.clear_seen <= s.clear_seen;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		samples_sent++;
	endtask

	task automatic drive_run();
		wave_shape_e shape;
		int unsigned pick;
		int unsigned hi;
		int unsigned lo;
		int unsigned seg_left;
		logic        cur;
		pin_sample_t s;
		pick = $urandom_range(0, 99);
		shape = pick < 60 ? SHAPE_SQUARE : pick < 80 ? SHAPE_JITTER : pick < 90 ? SHAPE_NOISE
			: SHAPE_STUCK;
		if (shape == SHAPE_STUCK && reg_timeout > 16) begin
			shape = SHAPE_SQUARE;
		end
		if ($urandom_range(0, 9) < 7) begin
			hi = phase_hi;
			lo = phase_lo;
		end else if ($urandom_range(0, 4) != 0) begin
			hi = $urandom_range(1, 4);
			lo = $urandom_range(1, 4);
		end else begin
			hi = $urandom_range(1, 12);
			lo = $urandom_range(1, 12);
		end
		cur = 1'($urandom_range(0, 1));
		seg_left = cur ? hi : lo;
		if (det_phase == PH_IDLE) begin
			s.level = cur;
			s.start_req = 1'b1;
			s.clear_seen = ($urandom_range(0, 4) == 0);
			offer_sample(s, 1'b0, '0);
			seg_left--;
		end
		while (det_phase != PH_IDLE) begin
			if (seg_left == 0) begin
				cur = ~cur;
				seg_left = cur ? hi : lo;
				case (shape)
					SHAPE_JITTER: begin
						seg_left = $urandom_range(seg_left > 1 ? seg_left - 1 : 1, seg_left + 1);
					end
					SHAPE_STUCK: begin
						if ($urandom_range(0, 2) == 0) begin
							seg_left = reg_timeout + 1 + $urandom_range(0, 2);
						end
					end
					default: begin
					end
				endcase
			end
			if (shape == SHAPE_NOISE) begin
				cur = 1'($urandom_range(0, 1));
			end
			s.level = cur;
			s.start_req = ($urandom_range(0, 9) == 0);
			s.clear_seen = ($urandom_range(0, 4) == 0);
			offer_sample(s, 1'b0, '0);
			seg_left--;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_TIMEOUT:  reg_timeout = data;
			REG_TPS:      reg_tps = data;
			REG_CENTER_A: reg_center_a = data;
			REG_CENTER_B: reg_center_b = data;
			REG_TOL:      reg_tol = data[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic program_setting(input int unsigned idx);
		logic [15:0] tmo;
		logic [15:0] tps;
		logic [15:0] target;
		logic [15:0] ca;
		logic [15:0] cb;
		logic [7:0]  tol;
		int unsigned pick;
		if (idx == 0) begin
			phase_hi = 2;
			phase_lo = 3;
		end else begin
			if (idx == 1) begin
				tmo = 16'd0;
				tps = 16'd0;
				ca = 16'd0;
				cb = 16'd0;
				tol = 8'd0;
				phase_hi = 1;
				phase_lo = 1;
			end else if (idx == 2) begin
				tmo = 16'hFFFF;
				tps = 16'hFFFF;
				ca = 16'hFFFF;
				cb = 16'd32767;
				tol = 8'hFF;
				phase_hi = 1;
				phase_lo = 1;
			end else if (idx == 3) begin
				tmo = 16'd1;
				tps = 16'd1;
				ca = 16'd0;
				cb = 16'd0;
				tol = 8'hFF;
				phase_hi = 1;
				phase_lo = 2;
			end else begin
				phase_hi = $urandom_range(1, 4);
				phase_lo = $urandom_range(1, 4);
				pick = $urandom_range(0, 9);
				tmo = pick < 5 ? 16'($urandom_range(1, 16)) : pick < 8
					? 16'($urandom_range(17, 200)) : 16'($urandom_range(201, 65535));
				tps = 16'($urandom_range(1, 65535));
				target = tps / 16'(phase_hi + phase_lo);
				ca = 16'($urandom_range(0, 65535));
				cb = 16'($urandom_range(0, 65535));
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					ca = target;
				end else if (pick < 6) begin
					cb = target;
				end
				pick = $urandom_range(0, 9);
				tol = pick < 2 ? 8'd0 : pick < 6 ? 8'($urandom_range(1, 8))
					: 8'($urandom_range(0, 255));
			end
			write_reg(REG_TIMEOUT, tmo);
			write_reg(REG_TPS, tps);
			write_reg(REG_CENTER_A, ca);
			write_reg(REG_CENTER_B, cb);
			write_reg(REG_TOL, {8'($urandom_range(0, 255)), tol});
		end
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_TOL) + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		smp.valid <= 1'b0;
		while (predicted_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		pin_sample_t s;
		int unsigned ph;
		int unsigned runs;
		smp.valid = 1'b0;
		smp.level = 1'b0;
		smp.start_req = 1'b0;
		smp.clear_seen = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		reg_timeout = TIMEOUT_RST;
		reg_tps = TPS_RST;
		reg_center_a = CENTER_A_RST;
		reg_center_b = CENTER_B_RST;
		reg_tol = TOL_RST;
		det_phase = PH_IDLE;
		det_wait_level = 1'b0;
		det_wait_cnt = '0;
		det_per_cnt = '0;
		det_index = '0;
		det_sum = '0;
		det_seen = 1'b0;
		det_mean = '0;
		det_period = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			offer_sample(directed_rows[i].pin, directed_rows[i].known, directed_rows[i].want);
		end
		drive_run();
		ph = 0;
		while (ph < FIXED_SETTINGS || samples_sent < DIR_ROWS + RANDOM_ITEMS) begin
			settle();
			program_setting(ph);
			settings_used++;
			runs = $urandom_range(1, 2);
			repeat (runs) begin
				repeat ($urandom_range(0, 4)) begin
					s.level = 1'($urandom_range(0, 1));
					s.start_req = 1'b0;
					s.clear_seen = 1'($urandom_range(0, 1));
					offer_sample(s, 1'b0, '0);
				end
				drive_run();
			end
			ph++;
		end
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d sample transactions under %0d register settings.",
			samples_sent, settings_used);
		$display("%0d detection runs finished, %0d flagged a signal, %0d mismatches.",
			runs_done, presence_hits, mismatches);
		if (mismatches == 0 && predicted_status.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : result_sink
		logic        held;
		int unsigned pick;
		held = 1'b0;
		res.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (!held && samples_sent >= HOLD_AFTER) begin
				held = 1'b1;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (pick < 55) begin
				res.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else if (pick < 92) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res.ready <= 1'b0;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end
		end
	end

	initial begin : check_results
		det_status_t got;
		det_status_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				got = '{res.busy_res, res.done_res, res.signal_present, res.avg_frequency,
					res.last_period_ticks};
				if (predicted_status.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("%0t: result with none predicted: busy=%0b done=%0b present=%0b",
							$time, got.busy, got.done, got.present);
					end
				end else begin
					want = predicted_status.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("%0t: expected busy=%0b done=%0b present=%0b mean=%h period=%0d",
								$time, want.busy, want.done, want.present, want.mean, want.period);
							$display("%0t:   actual busy=%0b done=%0b present=%0b mean=%h period=%0d",
								$time, got.busy, got.done, got.present, got.mean, got.period);
						end
					end
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.", cycles,
			predicted_status.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
